/* sv/trc_pkg.sv */
package trc_pkg;

   localparam int READING_W = 24;
   localparam int TICKS_W   = 20;
   localparam int CHANNELS  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 8;

   typedef logic signed [READING_W-1:0] trc_reading_type;
   typedef logic [TICKS_W-1:0] trc_ticks_type;

   typedef enum logic [1:0] {
      OP_SENSOR = 2'd0,
      OP_TICK   = 2'd1,
      OP_MODE   = 2'd2,
      OP_MANUAL = 2'd3
   } trc_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LIMIT_SOIL  = 3'd0,
      REG_LIMIT_TEMP  = 3'd1,
      REG_LIMIT_LIGHT = 3'd2,
      REG_LIMIT_HUM   = 3'd3,
      REG_POLARITY    = 3'd4,
      REG_RUN_TICKS   = 3'd5,
      REG_REST_TICKS  = 3'd6
   } trc_reg_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_RUN  = 3'b010,
      PH_REST = 3'b100
   } trc_phase_type;

   localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_CODE_RUN  = 2'd1;
   localparam logic [1:0] PHASE_CODE_REST = 2'd2;

   localparam trc_reading_type LIMIT_SOIL_RESET  = 24'sd640;
   localparam trc_reading_type LIMIT_TEMP_RESET  = 24'sd512;
   localparam trc_reading_type LIMIT_LIGHT_RESET = 24'sd1600;
   localparam trc_reading_type LIMIT_HUM_RESET   = 24'sd960;
   localparam logic [CHANNELS-1:0] POLARITY_RESET = 4'b0010;
   localparam trc_ticks_type RUN_TICKS_RESET  = 20'd30000;
   localparam trc_ticks_type REST_TICKS_RESET = 20'd10000;

   typedef struct packed {
      trc_ticks_type run_ticks;
      trc_ticks_type rest_ticks;
   } trc_timer_cfg_type;

   // Packed so that relay_drive sits in the lowest bits of the stream word.
   typedef struct packed {
      logic            status_event;
      logic [1:0]      pump_phase;
      logic            auto_active;
      logic [CHANNELS-1:0] relay_drive;
   } trc_rsp_type;

   function automatic logic [1:0] phase_code(trc_phase_type ph);
      logic [1:0] code;
      case (ph)
         PH_IDLE: code = PHASE_CODE_IDLE;
         PH_RUN:  code = PHASE_CODE_RUN;
         PH_REST: code = PHASE_CODE_REST;
         default: code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* sv/trc_lane.sv */
module trc_lane (
   input  trc_pkg::trc_reading_type reading,
   input  trc_pkg::trc_reading_type limit,
   input  logic                     above,
   output logic                     cond
);
   import trc_pkg::*;

   // An equal reading is false for either polarity.
   always_comb begin
      if (above) begin
         cond = (reading > limit);
      end else begin
         cond = (reading < limit);
      end
   end

endmodule

/* sv/trc_ctrl.sv */
module trc_ctrl #(
   parameter int TIMER_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  trc_pkg::trc_op_type        operation,
   input  logic                       auto_request,
   input  logic [1:0]                 relay_index,
   input  logic                       relay_value,
   input  logic [trc_pkg::CHANNELS-1:0] cond,
   input  trc_pkg::trc_timer_cfg_type timer_cfg,
   output trc_pkg::trc_rsp_type       rsp
);
   import trc_pkg::*;

   localparam int CMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   logic [CHANNELS-1:0]   relay_ff, relay_in;
   logic                  auto_ff, auto_in;
   trc_phase_type         phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [CMP_W-1:0]      elapsed_wide, run_wide, rest_wide;
   logic                  event_bit;

   // The counter saturates, so a time longer than the timer can hold never ends.
   assign elapsed_inc  = (elapsed_ff == TIMER_MAX) ? elapsed_ff
                                                   : elapsed_ff + TIMER_BITS'(1);
   assign elapsed_wide = CMP_W'(elapsed_inc);
   assign run_wide     = CMP_W'(timer_cfg.run_ticks);
   assign rest_wide    = CMP_W'(timer_cfg.rest_ticks);

   always_comb begin
      relay_in   = relay_ff;
      auto_in    = auto_ff;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      event_bit  = 1'b0;
      case (operation)
         OP_SENSOR: begin
            if (auto_ff) begin
               if (!cond[0]) begin
                  phase_in    = PH_IDLE;
                  relay_in[0] = 1'b0;
               end else if (phase_ff == PH_IDLE) begin
                  phase_in    = PH_RUN;
                  elapsed_in  = '0;
                  relay_in[0] = 1'b1;
               end
               relay_in[CHANNELS-1:1] = cond[CHANNELS-1:1];
               event_bit = 1'b1;
            end
         end
         OP_TICK: begin
            if (phase_ff inside {PH_RUN, PH_REST}) begin
               elapsed_in = elapsed_inc;
               if (phase_ff == PH_RUN) begin
                  if (elapsed_wide >= run_wide) begin
                     phase_in    = PH_REST;
                     elapsed_in  = '0;
                     relay_in[0] = 1'b0;
                  end
               end else if (elapsed_wide >= rest_wide) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         OP_MODE: begin
            auto_in   = auto_request;
            event_bit = 1'b1;
         end
         OP_MANUAL: begin
            if (!auto_ff) begin
               relay_in[relay_index] = relay_value;
            end
            event_bit = 1'b1;
         end
         default: begin
            event_bit = 1'b0;
         end
      endcase
   end

   assign rsp.relay_drive  = relay_in;
   assign rsp.auto_active  = auto_in;
   assign rsp.pump_phase   = phase_code(phase_in);
   assign rsp.status_event = event_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff   <= '0;
         auto_ff    <= 1'b1;
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
      end else if (push) begin
         relay_ff   <= relay_in;
         auto_ff    <= auto_in;
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

/* sv/trc_obuf.sv */
module trc_obuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  trc_pkg::trc_rsp_type push_data,
   output logic                 space,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output trc_pkg::trc_rsp_type rsp_data
);
   import trc_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   trc_rsp_type out_ff, out_in;
   trc_rsp_type skid_ff, skid_in;
   logic        pop;

   // The skid stage takes a new word while the output word is still stalled.
   assign space = !skid_valid_ff;
   assign pop   = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = push_data;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_ff;

endmodule

/* sv/threshold_relay_controller_core.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser operation; tdata readings and write fields
// rsp      out        rsp_tvalid/rsp_tready  tdata relays, mode, pump phase, status flag
// csr      in         csr_we                 csr_index, csr_wdata
//
// The four comparator lanes and the pump update sit between the request port and
// the output register, so a word may enter each cycle while req_tready is high.
// The result is registered. A two-word output stage (output register plus skid
// register) keeps req_tready high while one result is stalled.
// Reset is synchronous and restores register defaults, auto mode and an idle pump.
module threshold_relay_controller_core #(
   parameter int TIMER_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // reading_soil, reading_temp, reading_light, reading_air_hum, auto_request,
   // relay_index, relay_value, zero fill
   input  logic [trc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // relay_drive, auto_active, pump_phase_out, status_event
   output logic [trc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [trc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [trc_pkg::READING_W-1:0]     csr_wdata
);
   import trc_pkg::*;

   trc_reading_type     limit_ff [CHANNELS];
   logic [CHANNELS-1:0] polarity_ff;
   trc_timer_cfg_type   timer_cfg_ff;

   trc_reading_type     reading [CHANNELS];
   logic [CHANNELS-1:0] cond;
   logic                push;
   trc_rsp_type         rsp_next, rsp_word;
   logic                space;

   assign reading[0] = req_tdata[23:0];
   assign reading[1] = req_tdata[47:24];
   assign reading[2] = req_tdata[71:48];
   assign reading[3] = req_tdata[95:72];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff[0]             <= LIMIT_SOIL_RESET;
         limit_ff[1]             <= LIMIT_TEMP_RESET;
         limit_ff[2]             <= LIMIT_LIGHT_RESET;
         limit_ff[3]             <= LIMIT_HUM_RESET;
         polarity_ff             <= POLARITY_RESET;
         timer_cfg_ff.run_ticks  <= RUN_TICKS_RESET;
         timer_cfg_ff.rest_ticks <= REST_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_LIMIT_SOIL:  limit_ff[0] <= csr_wdata;
            REG_LIMIT_TEMP:  limit_ff[1] <= csr_wdata;
            REG_LIMIT_LIGHT: limit_ff[2] <= csr_wdata;
            REG_LIMIT_HUM:   limit_ff[3] <= csr_wdata;
            REG_POLARITY:    polarity_ff <= csr_wdata[CHANNELS-1:0];
            REG_RUN_TICKS:   timer_cfg_ff.run_ticks  <= csr_wdata[TICKS_W-1:0];
            REG_REST_TICKS:  timer_cfg_ff.rest_ticks <= csr_wdata[TICKS_W-1:0];
            default: begin
               // Writes above the register list are dropped.
            end
         endcase
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      trc_lane u_lane (
         .reading (reading[g]),
         .limit   (limit_ff[g]),
         .above   (polarity_ff[g]),
         .cond    (cond[g])
      );
   end

   assign req_tready = space;
   assign push       = req_tvalid && space;

   trc_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .operation    (trc_op_type'(req_tuser)),
      .auto_request (req_tdata[96]),
      .relay_index  (req_tdata[98:97]),
      .relay_value  (req_tdata[99]),
      .cond         (cond),
      .timer_cfg    (timer_cfg_ff),
      .rsp          (rsp_next)
   );

   trc_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (rsp_next),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_word)
   );

   assign rsp_tdata = rsp_word;

endmodule
